/* src/quarter_rate_shift_hilbert_iq_unit_macros.svh */
// assertion macros shared by the checker
`ifndef QUARTER_RATE_SHIFT_HILBERT_IQ_UNIT_MACROS_SVH
`define QUARTER_RATE_SHIFT_HILBERT_IQ_UNIT_MACROS_SVH
// a implies b on the next clock edge
`define QRS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("qrs check failed");
// a implies b on the same clock edge
`define QRS_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("qrs check failed");
`endif

/* src/qrs_hilb_pkg.sv */
// shared types and constants for the quarter-rate shift hilbert unit
package qrs_hilb_pkg;
    localparam int GUARD_BITS = 4;
    localparam int WORD_BITS = 32;
    localparam int ROWS = 8;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_LOAD, t_ST_MAC, t_ST_END, t_ST_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic       clear_acc;
        logic       mac;
        logic [2:0] tap;
        logic       finish_sec;
        logic       finish_out;
    } t_cmd;

    function automatic logic signed [31:0] coef_q30(input logic [2:0] row,
                                                    input logic [2:0] k);
        logic signed [31:0] c;
        c = 32'sd0;
        unique case (row)
            3'd0: unique case (k)
                3'd0, 3'd2: c = 32'sd270098134;
                3'd1: c = 32'sd540196268;
                3'd4: c = -32'sd6650712;
                default: c = 32'sd0;
            endcase
            3'd1: unique case (k)
                3'd0, 3'd2: c = 32'sd283907488;
                3'd1: c = 32'sd567814976;
                3'd4: c = -32'sd61888128;
                default: c = 32'sd0;
            endcase
            3'd2: unique case (k)
                3'd0, 3'd2: c = 32'sd314491699;
                3'd1: c = 32'sd628983398;
                3'd4: c = -32'sd184224972;
                default: c = 32'sd0;
            endcase
            3'd3: unique case (k)
                3'd0, 3'd2: c = 32'sd369239629;
                3'd1: c = 32'sd738479258;
                3'd4: c = -32'sd403216690;
                default: c = 32'sd0;
            endcase
            3'd4: unique case (k)
                3'd0, 3'd2: c = 32'sd464246724;
                3'd1: c = 32'sd928493448;
                3'd4: c = -32'sd783245072;
                default: c = 32'sd0;
            endcase
            default: c = (k == 3'd0) ? 32'sd1073741824 : 32'sd0;
        endcase
        return c;
    endfunction
endpackage

/* src/qrs_ctrl.sv */
// sequencer: walks three cascades, five taps per section
module qrs_ctrl #(
    parameter int SECTIONS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output qrs_hilb_pkg::t_cmd   o_cmd,
    output logic [1:0]           o_path,
    output logic [2:0]           o_sec
);
    import qrs_hilb_pkg::*;
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    t_state r_state, n_state;
    logic [1:0] r_path, n_path;
    logic [SW-1:0] r_sec, n_sec;
    logic [2:0] r_tap, n_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_path <= '0;
            r_sec <= '0;
            r_tap <= '0;
        end else begin
            r_state <= n_state;
            r_path <= n_path;
            r_sec <= n_sec;
            r_tap <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_path = r_path;
        n_sec = r_sec;
        n_tap = r_tap;
        o_cmd = '0;
        o_cmd.tap = r_tap;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            t_ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = t_ST_LOAD;
                    n_path = 2'd0;
                    n_sec = '0;
                end
            end
            t_ST_LOAD: begin
                o_cmd.clear_acc = 1'b1;
                n_tap = 3'd0;
                n_state = t_ST_MAC;
            end
            t_ST_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_tap == 3'd4) n_state = t_ST_END;
                else n_tap = r_tap + 3'd1;
            end
            t_ST_END: begin
                o_cmd.finish_sec = 1'b1;
                if (r_sec == SW'(SECTIONS - 1)) begin
                    n_sec = '0;
                    if (r_path == 2'd2) begin
                        o_cmd.finish_out = 1'b1;
                        n_state = t_ST_OUT;
                    end else begin
                        n_path = r_path + 2'd1;
                        n_state = t_ST_LOAD;
                    end
                end else begin
                    n_sec = r_sec + SW'(1);
                    n_state = t_ST_LOAD;
                end
            end
            t_ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = t_ST_IDLE;
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    assign o_path = r_path;
    assign o_sec = 3'(r_sec);
endmodule

/* src/qrs_dp.sv */
// datapath: shared multiply-accumulate, delay banks, rotation and output
module qrs_dp #(
    parameter int SECTIONS = 5,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qrs_hilb_pkg::t_cmd            i_cmd,
    input  logic [1:0]                    i_path,
    input  logic [2:0]                    i_sec,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_in_phase,
    output logic signed [SAMPLE_BITS-1:0] o_quadrature,
    output logic                          o_clipped
);
    import qrs_hilb_pkg::*;
    localparam int FRAC = WORD_BITS - SAMPLE_BITS - GUARD_BITS;
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int SH = COEF_BITS - 2;
    localparam logic signed [31:0] WMAX = 32'sh7fffffff;
    localparam logic signed [31:0] WMIN = 32'sh80000000;

    // one delay bank per path, four words per section
    logic signed [31:0] r_dl_f [SECTIONS][4];
    logic signed [31:0] r_dl_i [SECTIONS][4];
    logic signed [31:0] r_dl_q [SECTIONS][4];
    logic signed [31:0] r_x, n_x, r_fi, r_b;
    logic signed [63:0] r_acc;
    logic [1:0] r_phase;
    logic signed [SAMPLE_BITS-1:0] r_oi, r_oq;
    logic r_clip;

    logic [SW-1:0] sidx;
    logic signed [31:0] cur [4];
    logic signed [31:0] opnd, coefv, y, neg_y, rot_a, rot_b;
    logic signed [63:0] prod, rnd, sh;
    logic last_sec;

    assign sidx = SW'(i_sec);
    assign last_sec = (i_sec == 3'(SECTIONS - 1));
    assign coefv = coef_q30(i_sec, i_cmd.tap) >>> (32 - COEF_BITS);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            unique case (i_path)
                2'd0: cur[k] = r_dl_f[sidx][k];
                2'd1: cur[k] = r_dl_i[sidx][k];
                default: cur[k] = r_dl_q[sidx][k];
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.tap)
            3'd0: opnd = r_x;
            3'd1: opnd = cur[0];
            3'd2: opnd = cur[1];
            3'd3: opnd = cur[2];
            default: opnd = cur[3];
        endcase
    end
    assign prod = 64'(coefv) * 64'(opnd);
    assign rnd = r_acc + (64'sd1 <<< (COEF_BITS - 3));
    assign sh = rnd >>> SH;
    assign y = (sh > 64'(WMAX)) ? WMAX : (sh < 64'(WMIN)) ? WMIN : sh[31:0];
    assign neg_y = (y == WMIN) ? WMAX : -y;

    // rotate in: front output steered into i or q with a sign
    assign rot_a = (r_phase == 2'd0) ? y : (r_phase == 2'd2) ? neg_y : '0;
    assign rot_b = (r_phase == 2'd3) ? y : (r_phase == 2'd1) ? neg_y : '0;

    always_comb begin
        n_x = r_x;
        if (i_cmd.start) begin
            n_x = 32'(i_sample) <<< FRAC;
        end else if (i_cmd.finish_sec) begin
            if (last_sec && i_path == 2'd0) n_x = rot_a;
            else if (last_sec && i_path == 2'd1) n_x = r_b;
            else n_x = y;
        end
    end

    function automatic logic signed [SAMPLE_BITS:0] to_smp(
        input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + (34'sd1 <<< (FRAC - 2))) >>> (FRAC - 1);
        if (r > 34'sd0 + ((34'sd1 <<< (SAMPLE_BITS - 1)) - 1))
            return {1'b1, 1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        if (r < -(34'sd1 <<< (SAMPLE_BITS - 1)))
            return {1'b1, 1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        return {1'b0, r[SAMPLE_BITS-1:0]};
    endfunction

    logic signed [33:0] vi, vq, ei, eq;
    logic signed [SAMPLE_BITS:0] si, sq;
    assign ei = 34'(r_fi);
    assign eq = 34'(y);
    always_comb begin
        unique case (r_phase)
            2'd0: begin vi = ei; vq = eq; end
            2'd1: begin vi = -eq; vq = ei; end
            2'd2: begin vi = -ei; vq = -eq; end
            default: begin vi = eq; vq = -ei; end
        endcase
    end
    assign si = to_smp(vi);
    assign sq = to_smp(vq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            for (int s = 0; s < SECTIONS; s++) begin
                for (int k = 0; k < 4; k++) begin
                    r_dl_f[s][k] <= '0;
                    r_dl_i[s][k] <= '0;
                    r_dl_q[s][k] <= '0;
                end
            end
        end else begin
            r_x <= n_x;
            if (i_cmd.clear_acc) r_acc <= '0;
            else if (i_cmd.mac) r_acc <= r_acc + prod;
            if (i_cmd.finish_sec) begin
                unique case (i_path)
                    2'd0: begin
                        r_dl_f[sidx][1] <= r_dl_f[sidx][0];
                        r_dl_f[sidx][0] <= r_x;
                        r_dl_f[sidx][3] <= r_dl_f[sidx][2];
                        r_dl_f[sidx][2] <= y;
                    end
                    2'd1: begin
                        r_dl_i[sidx][1] <= r_dl_i[sidx][0];
                        r_dl_i[sidx][0] <= r_x;
                        r_dl_i[sidx][3] <= r_dl_i[sidx][2];
                        r_dl_i[sidx][2] <= y;
                    end
                    default: begin
                        r_dl_q[sidx][1] <= r_dl_q[sidx][0];
                        r_dl_q[sidx][0] <= r_x;
                        r_dl_q[sidx][3] <= r_dl_q[sidx][2];
                        r_dl_q[sidx][2] <= y;
                    end
                endcase
                if (last_sec && i_path == 2'd0) r_b <= rot_b;
                if (last_sec && i_path == 2'd1) r_fi <= y;
            end
            if (i_cmd.finish_out) begin
                r_oi <= si[SAMPLE_BITS-1:0];
                r_oq <= sq[SAMPLE_BITS-1:0];
                r_clip <= si[SAMPLE_BITS] | sq[SAMPLE_BITS];
                r_phase <= r_phase + 2'd1;
            end
        end
    end

    assign o_in_phase = r_oi;
    assign o_quadrature = r_oq;
    assign o_clipped = r_clip;
endmodule

/* src/quarter_rate_shift_hilbert_iq_unit.sv */
// each biquad section runs load, five multiply-accumulate taps and end, over
// 3*SECTIONS sections in all, one item at a time
// a new item waits for the last output transfer, paced by the single shared
// multiply-accumulate unit that runs all five taps of every section
// reset: synchronous active low, clears phase, all delay words and control
module quarter_rate_shift_hilbert_iq_unit #(
    parameter int SECTIONS = 5,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_in_phase,
    output logic signed [SAMPLE_BITS-1:0] o_quadrature,
    output logic                          o_clipped
);
    import qrs_hilb_pkg::*;
    t_cmd cmd;
    logic [1:0] path;
    logic [2:0] sec;

    qrs_ctrl #(.SECTIONS(SECTIONS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(cmd), .o_path(path), .o_sec(sec)
    );
    qrs_dp #(.SECTIONS(SECTIONS), .SAMPLE_BITS(SAMPLE_BITS),
             .COEF_BITS(COEF_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_path(path), .i_sec(sec),
        .i_sample, .o_in_phase, .o_quadrature, .o_clipped
    );
endmodule

/* src/qrs_checker.sv */
// port-level checker bound to the top level
`include "quarter_rate_shift_hilbert_iq_unit_macros.svh"
module qrs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready
);
    `QRS_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `QRS_ASSERT_NOW(a_one_at_a_time, i_clk, i_rst_n, o_valid, !o_ready)
    `QRS_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)
endmodule

bind quarter_rate_shift_hilbert_iq_unit qrs_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready
);

/* sim/tb_top.sv */
// testbench for the quarter-rate shift hilbert i/q unit
`timescale 1ns / 100ps

module tb_top;
    import qrs_hilb_pkg::*;

    localparam int NSEC = 5;
    localparam int SBITS = 16;
    localparam int FBITS = 32 - SBITS - GUARD_BITS;

    typedef struct packed {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
        logic               clip;
    } iq_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [15:0] i_sample = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [15:0] o_in_phase;
    logic signed [15:0] o_quadrature;
    logic o_clipped;

    quarter_rate_shift_hilbert_iq_unit u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0] rot_phase;
    logic signed [31:0] front_dly [20];
    logic signed [31:0] ip_dly [20];
    logic signed [31:0] qd_dly [20];
    iq_t iq_expected [$];
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;

    function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int n);
        return v >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] tap_coef(input int s, input int k);
        logic signed [31:0] tbl [5][5];
        tbl = '{'{270098134, 540196268, 270098134, 0, -6650712},
                '{283907488, 567814976, 283907488, 0, -61888128},
                '{314491699, 628983398, 314491699, 0, -184224972},
                '{369239629, 738479258, 369239629, 0, -403216690},
                '{464246724, 928493448, 464246724, 0, -783245072}};
        return 64'(tbl[s][k]);
    endfunction

    task automatic run_biquads(inout logic signed [31:0] d [20],
                               input logic signed [31:0] x_in,
                               output logic signed [31:0] y_out);
        logic signed [63:0] acc;
        logic signed [31:0] x, y;
        x = x_in;
        for (int s = 0; s < NSEC; s++) begin
            acc = tap_coef(s, 0) * 64'(x) + tap_coef(s, 1) * 64'(d[4*s])
                + tap_coef(s, 2) * 64'(d[4*s+1]) + tap_coef(s, 3) * 64'(d[4*s+2])
                + tap_coef(s, 4) * 64'(d[4*s+3]);
            acc += 64'sd1 <<< 29;
            y = clamp32(fshift(acc, 30));
            d[4*s+1] = d[4*s];
            d[4*s] = x;
            d[4*s+3] = d[4*s+2];
            d[4*s+2] = y;
            x = y;
        end
        y_out = x;
    endtask

    function automatic logic signed [15:0] to_q15(input logic signed [63:0] v,
                                                  inout logic clip);
        logic signed [63:0] r;
        r = fshift(v + (64'sd1 <<< (FBITS - 2)), FBITS - 1);
        if (r > 64'sd32767) begin clip = 1'b1; return 16'sh7fff; end
        if (r < -64'sd32768) begin clip = 1'b1; return 16'sh8000; end
        return r[15:0];
    endfunction

    task automatic predict_iq(input logic signed [15:0] smp);
        logic signed [31:0] xf, a, b, fi, fq;
        logic signed [63:0] oi, oq;
        iq_t r;
        r.clip = 1'b0;
        a = 0;
        b = 0;
        run_biquads(front_dly, 32'(smp) <<< FBITS, xf);
        case (rot_phase)
            2'd0: a = xf;
            2'd1: b = clamp32(-64'(xf));
            2'd2: a = clamp32(-64'(xf));
            default: b = xf;
        endcase
        run_biquads(ip_dly, a, fi);
        run_biquads(qd_dly, b, fq);
        case (rot_phase)
            2'd0: begin oi = fi; oq = fq; end
            2'd1: begin oi = -64'(fq); oq = fi; end
            2'd2: begin oi = -64'(fi); oq = -64'(fq); end
            default: begin oi = fq; oq = -64'(fi); end
        endcase
        r.i_val = to_q15(oi, r.clip);
        r.q_val = to_q15(oq, r.clip);
        iq_expected.push_back(r);
        rot_phase = rot_phase + 2'd1;
    endtask

    // valid stays up between back-to-back items; dropped only while idling
    task automatic send_sample(input logic signed [15:0] smp);
        while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_iq(smp);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (iq_expected.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // receiver stall pattern
    always @(negedge i_clk)
        i_ready <= i_rst_n && !(recv_stall > 0 && $urandom_range(99, 0) < recv_stall);

    always @(posedge i_clk) begin
        iq_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (iq_expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer %0d %0d %0d",
                                           o_in_phase, o_quadrature, o_clipped);
            end else begin
                e = iq_expected.pop_front();
                if (o_in_phase !== e.i_val || o_quadrature !== e.q_val
                        || o_clipped !== e.clip) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                                 e.i_val, e.q_val, e.clip,
                                 o_in_phase, o_quadrature, o_clipped);
                end
            end
        end
    end

    task automatic test_extremes();
        logic signed [15:0] pat [6];
        pat = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh5555};
        for (int k = 0; k < 6; k++) send_sample(pat[k]);
        // full-scale squares at fs/4 and fs/2 drive toward clipping
        for (int k = 0; k < 8; k++) send_sample(k[1] ? 16'sh8000 : 16'sh7fff);
        for (int k = 0; k < 8; k++) send_sample(k[0] ? 16'sh8000 : 16'sh7fff);
        wait_drained();
    endtask

    task automatic test_random(input int n, input int s_idle, input int r_stall);
        send_idle = s_idle;
        recv_stall = r_stall;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3, 0))
                0: send_sample(16'($urandom()));
                1: send_sample($urandom_range(1, 0) ? 16'sh7fff : 16'sh8000);
                2: send_sample(16'($signed($urandom_range(200, 0)) - 100));
                default: send_sample(16'($urandom()) >>> $urandom_range(15, 0));
            endcase
        end
        wait_drained();
    endtask

    initial begin
        rot_phase = 2'd0;
        for (int k = 0; k < 20; k++) begin
            front_dly[k] = 0; ip_dly[k] = 0; qd_dly[k] = 0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_random(700, 0, 0);
        test_random(400, 88, 0);
        test_random(400, 0, 88);
        test_random(400, 14, 14);
        if (errors == 0 && iq_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/qrs_hilb_pkg.sv
src/qrs_ctrl.sv
src/qrs_dp.sv
src/quarter_rate_shift_hilbert_iq_unit.sv
src/qrs_checker.sv
sim/tb_top.sv
